// ===== rtl/salu_pkg.sv =====
// shared types and constants for the sized alu with condition flags
package salu_pkg;

	typedef enum logic [2:0] {
		KIND_AND = 3'd0,
		KIND_OR  = 3'd1,
		KIND_SHL = 3'd2,
		KIND_SHR = 3'd3,
		KIND_ADD = 3'd4,
		KIND_MUL = 3'd5
	} kind_t;

	typedef enum logic [1:0] {
		SIZE_BYTE = 2'd0,
		SIZE_HALF = 2'd1,
		SIZE_WORD = 2'd2
	} size_t;

	localparam int unsigned DataW = 32;
	localparam int unsigned FullW = 2 * DataW;

	localparam logic [DataW-1:0] MaskByte = 32'h0000_00ff;
	localparam logic [DataW-1:0] MaskHalf = 32'h0000_ffff;
	localparam logic [DataW-1:0] MaskWord = 32'hffff_ffff;

	function automatic logic [DataW-1:0] size_mask(input logic [1:0] sz);
		logic [DataW-1:0] m;
		case (sz)
			SIZE_BYTE: m = MaskByte;
			SIZE_HALF: m = MaskHalf;
			default:   m = MaskWord;
		endcase
		return m;
	endfunction

endpackage

// ===== rtl/sized_alu_with_flags_top.sv =====
// sized alu with condition flags: three-stage pipeline, top level
// Each beat carries one operation (and, or, shift left, shift right, add,
// multiply) on two operands masked to byte, halfword or word size, and
// returns the masked result with zero, negative, positive and overflow flags
// plus a flag write enable. The pipeline has three register stages (operand
// masking, the operation itself with a 32x32 multiplier, flag extraction), and
// one beat is accepted every cycle while out_ready is high. A stall holds
// every full stage; empty stages still fill, so in_ready drops only when all
// three are full and out_ready is low. Unknown operation or size codes give an
// all-zero result beat.
module sized_alu_with_flags_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  kind,
	input  logic [1:0]  size,
	input  logic [31:0] first_operand,
	input  logic [31:0] second_operand,
	input  logic        update_flags,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [31:0] result,
	output logic        zero_flag,
	output logic        negative_flag,
	output logic        positive_flag,
	output logic        ovf_flag,
	output logic        flags_write
);

	localparam int unsigned DataW = salu_pkg::DataW;
	localparam int unsigned FullW = salu_pkg::FullW;

	logic en1, en2, en3;

	// stage 1 registers
	logic                   valid_s1;
	logic                   legal_s1;
	salu_pkg::kind_t        kind_s1;
	logic [1:0]             size_s1;
	logic [DataW-1:0]       a_s1;
	logic [DataW-1:0]       b_s1;
	logic                   upd_s1;

	// stage 2 registers
	logic                   valid_s2;
	logic                   legal_s2;
	logic [1:0]             size_s2;
	logic [FullW-1:0]       full_s2;
	logic                   upd_s2;

	// stage 3 registers
	logic                   valid_s3;
	logic [DataW-1:0]       res_s3;
	logic                   zero_s3;
	logic                   neg_s3;
	logic                   pos_s3;
	logic                   ovf_s3;
	logic                   wr_s3;

	logic                   legal_in;
	logic [DataW-1:0]       mask_in;
	logic                   shamt_big;
	logic [FullW-1:0]       full_c;
	logic [DataW-1:0]       res_c;
	logic                   top_c;
	logic                   ovf_c;

	assign en3      = !valid_s3 || out_ready;
	assign en2      = !valid_s2 || en3;
	assign en1      = !valid_s1 || en2;
	assign in_ready = en1;

	// stage 1: decode and mask operands
	assign legal_in = (kind <= salu_pkg::KIND_MUL) && (size <= salu_pkg::SIZE_WORD);
	assign mask_in  = salu_pkg::size_mask(size);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (en1) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en1 && in_valid) begin
			legal_s1 <= legal_in;
			kind_s1  <= salu_pkg::kind_t'(kind);
			size_s1  <= size;
			a_s1     <= first_operand & mask_in;
			b_s1     <= second_operand & mask_in;
			upd_s1   <= update_flags;
		end
	end

	// stage 2: the operation at full precision
	always_comb begin
		case (size_s1)
			salu_pkg::SIZE_BYTE: shamt_big = |b_s1[DataW-1:3];
			salu_pkg::SIZE_HALF: shamt_big = |b_s1[DataW-1:4];
			default:             shamt_big = |b_s1[DataW-1:5];
		endcase
	end

	always_comb begin
		case (kind_s1)
			salu_pkg::KIND_AND: full_c = {{DataW{1'b0}}, a_s1 & b_s1};
			salu_pkg::KIND_OR:  full_c = {{DataW{1'b0}}, a_s1 | b_s1};
			salu_pkg::KIND_SHL: full_c = shamt_big ? '0 :
				({{DataW{1'b0}}, a_s1} << b_s1[4:0]);
			salu_pkg::KIND_SHR: full_c = shamt_big ? '0 :
				{{DataW{1'b0}}, a_s1 >> b_s1[4:0]};
			salu_pkg::KIND_ADD: full_c = {{(DataW-1){1'b0}},
				{1'b0, a_s1} + {1'b0, b_s1}};
			salu_pkg::KIND_MUL: full_c = a_s1 * b_s1;
			default:            full_c = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (en2) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2 && valid_s1) begin
			legal_s2 <= legal_s1;
			size_s2  <= size_s1;
			full_s2  <= legal_s1 ? full_c : '0;
			upd_s2   <= upd_s1;
		end
	end

	// stage 3: mask result and derive flags
	assign res_c = full_s2[DataW-1:0] & salu_pkg::size_mask(size_s2);

	always_comb begin
		case (size_s2)
			salu_pkg::SIZE_BYTE: begin
				top_c = full_s2[7];
				ovf_c = |full_s2[FullW-1:8];
			end
			salu_pkg::SIZE_HALF: begin
				top_c = full_s2[15];
				ovf_c = |full_s2[FullW-1:16];
			end
			default: begin
				top_c = full_s2[DataW-1];
				ovf_c = |full_s2[FullW-1:DataW];
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (en3) begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3 && valid_s2) begin
			res_s3  <= res_c;
			zero_s3 <= legal_s2 && (res_c == '0);
			neg_s3  <= (res_c != '0) && top_c;
			pos_s3  <= (res_c != '0) && !top_c;
			ovf_s3  <= legal_s2 && ovf_c;
			wr_s3   <= legal_s2 && upd_s2;
		end
	end

	assign out_valid     = valid_s3;
	assign result        = res_s3;
	assign zero_flag     = zero_s3;
	assign negative_flag = neg_s3;
	assign positive_flag = pos_s3;
	assign ovf_flag      = ovf_s3;
	assign flags_write   = wr_s3;

endmodule

// ===== tb/tb_top.sv =====
// testbench for the sized alu with condition flags, directed and random beats
`timescale 1ns / 1ps

module tb_top;

	localparam logic [2:0] KIND_RSVD6 = 3'd6;
	localparam logic [2:0] KIND_RSVD7 = 3'd7;
	localparam logic [1:0] SIZE_RSVD  = 2'd3;
	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned DRAIN_CYCLES = 8;

	typedef struct packed {
		logic [31:0] res;
		logic        zero;
		logic        neg;
		logic        pos;
		logic        ovf;
		logic        fwr;
	} alu_result_t;

	logic        clk;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  kind = '0;
	logic [1:0]  size = '0;
	logic [31:0] first_operand = '0;
	logic [31:0] second_operand = '0;
	logic        update_flags = 1'b0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [31:0] result;
	logic        zero_flag;
	logic        negative_flag;
	logic        positive_flag;
	logic        ovf_flag;
	logic        flags_write;

	alu_result_t expected_results[$];
	alu_result_t want;
	int unsigned send_idle_pct = 0;
	int unsigned recv_idle_pct = 0;
	int unsigned stall_cycles = 0;
	int unsigned mismatch_count = 0;
	int unsigned beats_sent = 0;
	int unsigned results_checked = 0;
	int unsigned unknown_sent = 0;

	sized_alu_with_flags_top i_dut (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.kind           (kind),
		.size           (size),
		.first_operand  (first_operand),
		.second_operand (second_operand),
		.update_flags   (update_flags),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.result         (result),
		.zero_flag      (zero_flag),
		.negative_flag  (negative_flag),
		.positive_flag  (positive_flag),
		.ovf_flag       (ovf_flag),
		.flags_write    (flags_write)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic alu_result_t predict_alu(logic [2:0] k, logic [1:0] s,
			logic [31:0] a_in, logic [31:0] b_in, logic upd);
		alu_result_t r;
		int unsigned w;
		logic [63:0] mask;
		logic [63:0] a;
		logic [63:0] b;
		logic [63:0] full;
		r = '0;
		if (k > salu_pkg::KIND_MUL || s > salu_pkg::SIZE_WORD)
			return r;
		w = (s == salu_pkg::SIZE_BYTE) ? 8 : (s == salu_pkg::SIZE_HALF) ? 16 : 32;
		mask = (64'd1 << w) - 64'd1;
		a = {32'd0, a_in} & mask;
		b = {32'd0, b_in} & mask;
		case (k)
			salu_pkg::KIND_AND: full = a & b;
			salu_pkg::KIND_OR:  full = a | b;
			salu_pkg::KIND_SHL: full = (b >= w) ? 64'd0 : (a << b[5:0]);
			salu_pkg::KIND_SHR: full = (b >= w) ? 64'd0 : (a >> b[5:0]);
			salu_pkg::KIND_ADD: full = a + b;
			default:            full = a * b;
		endcase
		r.res = full[31:0] & mask[31:0];
		r.zero = (r.res == 32'd0);
		if (r.res != 32'd0) begin
			r.neg = r.res[w-1];
			r.pos = ~r.res[w-1];
		end
		r.ovf = ((full >> w) != 64'd0);
		r.fwr = upd;
		return r;
	endfunction

	function automatic logic [31:0] rand_operand();
		case ($urandom_range(0, 5))
			0, 1:    return $urandom();
			2:       return $urandom_range(0, 3);
			3:       return $urandom() | 32'h8080_8080;
			4:       return 32'hffff_ffff;
			default: return 32'd1 << $urandom_range(0, 31);
		endcase
	endfunction

	task automatic check_field(string name, logic [31:0] exp_val, logic [31:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
			mismatch_count++;
		end
	endtask

	task automatic send_item(logic [2:0] k, logic [1:0] s, logic [31:0] a, logic [31:0] b,
			logic upd);
		while ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid       <= 1'b1;
		kind           <= k;
		size           <= s;
		first_operand  <= a;
		second_operand <= b;
		update_flags   <= upd;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
		end
	end

	// prediction on input beats, compare on output beats, stall watchdog
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) begin
				expected_results.push_back(predict_alu(kind, size, first_operand,
					second_operand, update_flags));
				beats_sent++;
				if (kind > salu_pkg::KIND_MUL || size > salu_pkg::SIZE_WORD)
					unknown_sent++;
			end
			if (out_valid && out_ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t: unexpected result beat, expected none, actual %h",
						$time, result);
					mismatch_count++;
				end else begin
					want = expected_results.pop_front();
					check_field("result", want.res, result);
					check_field("zero_flag", 32'(want.zero), 32'(zero_flag));
					check_field("negative_flag", 32'(want.neg), 32'(negative_flag));
					check_field("positive_flag", 32'(want.pos), 32'(positive_flag));
					check_field("ovf_flag", 32'(want.ovf), 32'(ovf_flag));
					check_field("flags_write", 32'(want.fwr), 32'(flags_write));
					results_checked++;
				end
			end
			if ((in_valid && in_ready) || (out_valid && out_ready))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("%0t: watchdog, %0d cycles without a beat, %0d results pending",
					$time, stall_cycles, expected_results.size());
				$display("Some tests failed");
				$finish;
			end
		end
	end

	task automatic test_bitwise();
		send_item(salu_pkg::KIND_AND, salu_pkg::SIZE_BYTE, 32'hffff_ff0f, 32'h1234_56ff, 1'b1);
		send_item(salu_pkg::KIND_OR, salu_pkg::SIZE_HALF, 32'hdead_0001, 32'hbeef_8000, 1'b1);
		send_item(salu_pkg::KIND_AND, salu_pkg::SIZE_WORD, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
		send_item(salu_pkg::KIND_AND, salu_pkg::SIZE_WORD, 32'haaaa_aaaa, 32'h5555_5555, 1'b1);
	endtask

	task automatic test_shifts();
		send_item(salu_pkg::KIND_SHL, salu_pkg::SIZE_BYTE, 32'h0000_0081, 32'h0000_0001, 1'b1);
		send_item(salu_pkg::KIND_SHR, salu_pkg::SIZE_HALF, 32'hffff_8000, 32'h0000_000f, 1'b1);
		send_item(salu_pkg::KIND_SHL, salu_pkg::SIZE_WORD, 32'hffff_ffff, 32'h0000_001f, 1'b1);
		send_item(salu_pkg::KIND_SHL, salu_pkg::SIZE_BYTE, 32'h0000_00ff, 32'hffff_ff08, 1'b1);
		send_item(salu_pkg::KIND_SHR, salu_pkg::SIZE_WORD, 32'hffff_ffff, 32'h0000_0020, 1'b1);
		send_item(salu_pkg::KIND_SHL, salu_pkg::SIZE_HALF, 32'h0000_1234, 32'h0000_ffff, 1'b1);
		send_item(salu_pkg::KIND_SHR, salu_pkg::SIZE_BYTE, 32'h0000_0080, 32'h0000_0000, 1'b0);
	endtask

	task automatic test_add_mul();
		send_item(salu_pkg::KIND_ADD, salu_pkg::SIZE_WORD, 32'hffff_ffff, 32'h0000_0001, 1'b1);
		send_item(salu_pkg::KIND_ADD, salu_pkg::SIZE_BYTE, 32'h0000_007f, 32'h0000_0001, 1'b1);
		send_item(salu_pkg::KIND_ADD, salu_pkg::SIZE_HALF, 32'h0000_ffff, 32'h0000_ffff, 1'b0);
		send_item(salu_pkg::KIND_MUL, salu_pkg::SIZE_HALF, 32'h0000_ffff, 32'h0000_ffff, 1'b1);
		send_item(salu_pkg::KIND_MUL, salu_pkg::SIZE_WORD, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
		send_item(salu_pkg::KIND_MUL, salu_pkg::SIZE_BYTE, 32'h0000_00ff, 32'h0000_0000, 1'b1);
	endtask

	task automatic test_unknown_codes();
		send_item(KIND_RSVD6, salu_pkg::SIZE_WORD, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
		send_item(KIND_RSVD7, salu_pkg::SIZE_BYTE, 32'h0000_0001, 32'h0000_0001, 1'b1);
		send_item(salu_pkg::KIND_ADD, SIZE_RSVD, 32'hffff_ffff, 32'h0000_0001, 1'b1);
	endtask

	task automatic test_random(int unsigned count);
		logic [2:0]  k;
		logic [1:0]  s;
		logic [31:0] a;
		logic [31:0] b;
		logic [31:0] low_mask;
		int unsigned w;
		for (int unsigned i = 0; i < count; i++) begin
			k = ($urandom_range(0, 99) < 94) ? 3'($urandom_range(0, 5)) :
				3'($urandom_range(6, 7));
			s = ($urandom_range(0, 99) < 92) ? 2'($urandom_range(0, 2)) : SIZE_RSVD;
			a = rand_operand();
			b = rand_operand();
			// most shifts take an amount from zero up to one above the size width
			if ((k == salu_pkg::KIND_SHL || k == salu_pkg::KIND_SHR) &&
					$urandom_range(0, 2) != 0) begin
				w = (s == salu_pkg::SIZE_BYTE) ? 8 : (s == salu_pkg::SIZE_HALF) ? 16 : 32;
				low_mask = (s == salu_pkg::SIZE_BYTE) ? salu_pkg::MaskByte :
					(s == salu_pkg::SIZE_HALF) ? salu_pkg::MaskHalf : salu_pkg::MaskWord;
				b = ($urandom() & ~low_mask) | $urandom_range(0, w + 1);
			end
			send_item(k, s, a, b, 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle_pct = 27;
		recv_idle_pct = 65;
		test_bitwise();
		test_shifts();
		test_add_mul();
		test_unknown_codes();
		test_random(370);

		send_idle_pct = 65;
		recv_idle_pct = 27;
		test_random(370);

		send_idle_pct = 0;
		recv_idle_pct = 0;
		test_random(370);

		in_valid <= 1'b0;
		while (expected_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("covered all six operations on byte, halfword and word, large shifts,");
		$display("carries and unknown codes: %0d beats in (%0d unknown), %0d results checked",
			beats_sent, unknown_sent, results_checked);
		if (mismatch_count == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
